/* design/mandelbrot_escape_time_pixel_core_macros.svh */
// Assertion macros used by the top level of the escape-time pixel core RTL.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked on clk_i, disabled while rst_ni is low.
`define MBROT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i at every edge, reset included.
`define MBROT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MBROT_ASSERT(lbl, prop, msg)
`define MBROT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/mbrot_pkg.sv */
// Package: types, constants and palette functions of the escape-time pixel core.
`timescale 1ns / 1ps
`default_nettype none

package mbrot_pkg;

  localparam int unsigned COORD_W  = 11;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STEP_W   = 28;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned GRID_SIZE = 2048;
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned PALETTE_DEPTH_DEF = 2048;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_BASE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd3;

  // Reset values
  localparam logic signed [WORD_W-1:0] X_BASE_RST     = -32'sd402653184;
  localparam logic signed [WORD_W-1:0] Y_BASE_RST     = 32'sd107374182;
  localparam logic [STEP_W-1:0]        PIXEL_STEP_RST = 28'd104858;
  localparam logic [CNT_W-1:0]         ITER_LIMIT_RST = 11'd2024;

  // Q28 angle constants for the palette
  localparam longint unsigned Q28_ONE            = 64'd268435456;
  localparam longint unsigned Q28_TWO_PI         = 64'd1686629713;
  localparam longint unsigned Q28_PI             = 64'd843314857;
  localparam longint unsigned Q28_HALF_PI        = 64'd421657428;
  localparam longint unsigned Q28_THIRD_TURN     = 64'd562209904;
  localparam longint unsigned Q28_TWO_THIRD_TURN = 64'd1124419809;
  localparam longint signed   CH_BIAS            = 64'sd4563402752;  // 17.0 in Q28
  localparam longint unsigned CH_SCALE           = 64'd7247757312;   // 27.0 in Q28

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pix_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [CNT_W-1:0]   iterations;
    logic               in_set;
  } pix_out_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic capture;   // load row/col from the input transaction
    logic reduce;    // wrap row/col into the grid
    logic map;       // form row*step and col*step
    logic init;      // form c, set z = c, clear the count
    logic mul;       // register the three products of z
    logic upd;       // write back z^2 + c, bump the count
    logic rom_rd;    // read the palette entry
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic row_ge;
    logic col_ge;
    logic cnt_lt_max;
    logic escape;
  } dp_sts_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Q16 fifth root, binary search over [0, 2^20)
  function automatic longint unsigned fifth_root_q16(input longint unsigned n);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    longint unsigned target;
    lo = 64'd0;
    hi = (64'd1 << 20) - 64'd1;
    target = n << 16;
    for (int i = 0; i < 21; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        p = mid;
        for (int k = 0; k < 4; k++) begin
          p = (p * mid) >> 16;
        end
        if (p <= target) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo;
  endfunction

  function automatic longint unsigned sine_div(input longint unsigned v, input int k);
    longint unsigned r;
    case (k)
      0:       r = v / 110;
      1:       r = v / 72;
      2:       r = v / 42;
      3:       r = v / 20;
      default: r = v / 6;
    endcase
    return r;
  endfunction

  // Q28 sine of an angle in [0, 2pi), Taylor series to x^11
  function automatic longint signed sine_q28(input longint unsigned a_in);
    longint unsigned a;
    longint unsigned x2;
    longint unsigned term;
    longint signed   s;
    logic            neg;
    a = a_in;
    neg = 1'b0;
    if (a >= Q28_PI) begin
      neg = 1'b1;
      a = a - Q28_PI;
    end
    if (a > Q28_HALF_PI) begin
      a = Q28_PI - a;
    end
    x2 = (a * a) >> 28;
    term = Q28_ONE;
    for (int k = 0; k < 5; k++) begin
      term = Q28_ONE - sine_div((x2 * term) >> 28, k);
    end
    s = signed'((a * term) >> 28);
    return neg ? -s : s;
  endfunction

  function automatic logic [COLOR_W-1:0] palette_channel(input longint unsigned t,
                                                         input longint unsigned offset);
    longint signed   s;
    longint unsigned num;
    longint unsigned v;
    s = sine_q28((t + offset) % Q28_TWO_PI);
    num = unsigned'(s * 64'sd10 + CH_BIAS);
    v = (num * 64'd255) / CH_SCALE;
    if (v > 64'd255) begin
      v = 64'd255;
    end
    return v[COLOR_W-1:0];
  endfunction

  function automatic rgb_t palette_entry(input int unsigned n);
    longint unsigned t;
    rgb_t            e;
    t = (64'd11 * fifth_root_q16(64'(n))) << 12;
    e.red   = palette_channel(t, 64'd0);
    e.green = palette_channel(t, Q28_THIRD_TURN);
    e.blue  = palette_channel(t, Q28_TWO_THIRD_TURN);
    return e;
  endfunction

endpackage

`default_nettype wire

/* design/mbrot_palette.sv */
// Palette ROM: colour per iteration count, built at elaboration, registered read.
`timescale 1ns / 1ps
`default_nettype none

module mbrot_palette #(
  parameter int unsigned PALETTE_DEPTH = mbrot_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned IDX_W = $clog2(PALETTE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  idx_i,
  output mbrot_pkg::rgb_t   rgb_o
);
  import mbrot_pkg::*;

  rgb_t rom [PALETTE_DEPTH];
  rgb_t rgb_q;

  for (genvar gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_rom
    localparam rgb_t ENTRY = palette_entry(gi);
    assign rom[gi] = ENTRY;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rgb_q <= rom[idx_i];
    end
  end

  assign rgb_o = rgb_q;

endmodule

`default_nettype wire

/* design/mbrot_dpath.sv */
// Datapath: grid mapping, shared complex-square unit, count, palette and result register.
`timescale 1ns / 1ps
`default_nettype none

module mbrot_dpath #(
  parameter int unsigned PALETTE_DEPTH = mbrot_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  mbrot_pkg::pix_in_t                     in_data_i,
  input  logic signed [mbrot_pkg::WORD_W-1:0]    x_base_i,
  input  logic signed [mbrot_pkg::WORD_W-1:0]    y_base_i,
  input  logic [mbrot_pkg::STEP_W-1:0]           pixel_step_i,
  input  logic [mbrot_pkg::CNT_W-1:0]            iter_limit_i,
  input  mbrot_pkg::dp_cmd_t                     cmd_i,
  output mbrot_pkg::dp_sts_t                     sts_o,
  output mbrot_pkg::pix_out_t                    out_data_o
);
  import mbrot_pkg::*;

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
  localparam int unsigned PROD_W = COORD_W + STEP_W;
  localparam logic [COORD_W-1:0] GRID_SUB = COORD_W'(GRID_SIZE);
  localparam logic signed [64:0] ESC_LIMIT = 65'sd4 <<< FRAC_BITS;

  logic [COORD_W-1:0]       row_q, col_q;
  logic [PROD_W-1:0]        prod_row_q, prod_col_q;
  logic signed [WORD_W-1:0] c_re_q, c_im_q, re_q, im_q;
  logic signed [63:0]       sq_re_q, sq_im_q, xprod_q;
  logic [CNT_W-1:0]         cnt_q;
  pix_out_t                 res_q;

  logic signed [63:0] re2, im2, re_im2;
  logic signed [64:0] mag2;
  logic [IDX_W-1:0]   pal_idx;
  rgb_t               pal_rgb;

  // floor shifts of the registered products
  assign re2    = sq_re_q >>> FRAC_BITS;
  assign im2    = sq_im_q >>> FRAC_BITS;
  assign re_im2 = xprod_q >>> (FRAC_BITS - 1);
  assign mag2   = 65'(re2) + 65'(im2);

  assign sts_o.row_ge     = 32'(row_q) >= 32'(GRID_SIZE);
  assign sts_o.col_ge     = 32'(col_q) >= 32'(GRID_SIZE);
  assign sts_o.cnt_lt_max = cnt_q < iter_limit_i;
  assign sts_o.escape     = mag2 > ESC_LIMIT;

  assign pal_idx = (32'(cnt_q) >= 32'(PALETTE_DEPTH - 1)) ? IDX_W'(PALETTE_DEPTH - 1)
                                                          : IDX_W'(cnt_q);

  mbrot_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .rd_en_i (cmd_i.rom_rd),
    .idx_i   (pal_idx),
    .rgb_o   (pal_rgb)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q <= in_data_i.row;
      col_q <= in_data_i.col;
    end else if (cmd_i.reduce) begin
      if (sts_o.row_ge) row_q <= row_q - GRID_SUB;
      if (sts_o.col_ge) col_q <= col_q - GRID_SUB;
    end

    if (cmd_i.map) begin
      prod_row_q <= PROD_W'(row_q) * PROD_W'(pixel_step_i);
      prod_col_q <= PROD_W'(col_q) * PROD_W'(pixel_step_i);
    end

    if (cmd_i.init) begin
      c_re_q <= sat32(66'(x_base_i) + 66'(prod_col_q));
      c_im_q <= sat32(66'(y_base_i) - 66'(prod_row_q));
      re_q   <= sat32(66'(x_base_i) + 66'(prod_col_q));
      im_q   <= sat32(66'(y_base_i) - 66'(prod_row_q));
      cnt_q  <= '0;
    end else if (cmd_i.upd) begin
      re_q  <= sat32(66'(c_re_q) + 66'(re2) - 66'(im2));
      im_q  <= sat32(66'(c_im_q) + 66'(re_im2));
      cnt_q <= cnt_q + CNT_W'(1);
    end

    if (cmd_i.mul) begin
      sq_re_q <= re_q * re_q;
      sq_im_q <= im_q * im_q;
      xprod_q <= re_q * im_q;
    end

    if (cmd_i.load_out) begin
      res_q.in_set     <= !sts_o.cnt_lt_max;
      res_q.iterations <= cnt_q;
      res_q.red        <= sts_o.cnt_lt_max ? pal_rgb.red   : '0;
      res_q.green      <= sts_o.cnt_lt_max ? pal_rgb.green : '0;
      res_q.blue       <= sts_o.cnt_lt_max ? pal_rgb.blue  : '0;
    end
  end

  assign out_data_o = res_q;

endmodule

`default_nettype wire

/* design/mbrot_ctrl.sv */
// Controller: sequences one pixel through the datapath and owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module mbrot_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  mbrot_pkg::dp_sts_t   sts_i,
  output mbrot_pkg::dp_cmd_t   cmd_o
);
  import mbrot_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_MAP    = 3'd2;
  localparam logic [2:0] ST_INIT   = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_UPD    = 3'd5;
  localparam logic [2:0] ST_COLOR  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (sts_i.row_ge || sts_i.col_ge) begin
          cmd_o.reduce = 1'b1;
        end else begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd_o.map = 1'b1;
        state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (sts_i.cnt_lt_max) begin
          cmd_o.mul = 1'b1;
          state_d = ST_UPD;
        end else begin
          state_d = ST_COLOR;
        end
      end
      ST_UPD: begin
        if (sts_i.escape) begin
          state_d = ST_COLOR;
        end else begin
          cmd_o.upd = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_COLOR: begin
        cmd_o.rom_rd = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* design/mandelbrot_escape_time_pixel_core.sv */
// Top level of the escape-time pixel core: config registers, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_time_pixel_core_macros.svh"

// Escape-time pixel core. Each input transaction carries one pixel (row,
// col); the core maps it to c = (x_base + col*step, y_base - row*step) in
// signed Q4.28, iterates z = z^2 + c from z = c with saturating updates, and
// returns one result transaction with the iteration count, an in-set flag and
// an RGB colour from an elaboration-time palette ROM (black when in the set).
// One pixel is in flight at a time. Each iteration uses the single
// complex-square unit: ST_MUL registers re*re, im*im and re*im on three
// 32x32 multipliers, then ST_UPD shifts, checks |z|^2 > 4 and writes back
// the saturated z. A finished result waits until the output register is
// free. The result sits in an output register, so the next input
// transaction is taken as soon as the current result is loaded, even while
// the result is stalled. There is no clearing pass after reset. Config writes
// (cfg_valid_i with cfg_ready_o, always ready) must only happen while the
// core is idle.
module mandelbrot_escape_time_pixel_core #(
  parameter int unsigned PALETTE_DEPTH = mbrot_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // pixel input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  mbrot_pkg::pix_in_t                    in_data_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output mbrot_pkg::pix_out_t                   out_data_o,
  // config write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mbrot_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mbrot_pkg::WORD_W-1:0]          cfg_data_i
);
  import mbrot_pkg::*;

  logic signed [WORD_W-1:0] x_base_q, y_base_q;
  logic [STEP_W-1:0]        pixel_step_q;
  logic [CNT_W-1:0]         iter_limit_q;
  logic                     cfg_we;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Config registers; always ready, a write is registered.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_base_q     <= X_BASE_RST;
      y_base_q     <= Y_BASE_RST;
      pixel_step_q <= PIXEL_STEP_RST;
      iter_limit_q <= ITER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_X_BASE:     x_base_q     <= cfg_data_i;
        CFG_Y_BASE:     y_base_q     <= cfg_data_i;
        CFG_PIXEL_STEP: pixel_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_ITER_LIMIT: iter_limit_q <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: accepts a transaction in idle, steps the datapath, and
  // loads the output register once it is free.
  mbrot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Grid mapping, shared square unit, palette ROM and result register.
  mbrot_dpath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .in_data_i    (in_data_i),
    .x_base_i     (x_base_q),
    .y_base_i     (y_base_q),
    .pixel_step_i (pixel_step_q),
    .iter_limit_i (iter_limit_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_data_o   (out_data_o)
  );

  // An accepted transaction keeps the core busy on the next cycle.
  `MBROT_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "no busy after accept")
  // A result may only be loaded when the output register is empty or draining.
  `MBROT_ASSERT(a_load_into_free_slot, cmd.load_out |-> (!out_valid_o || !out_stall_i), "result overwritten")
  // Points in the set are black.
  `MBROT_ASSERT_ALWAYS(a_in_set_black, (out_valid_o && out_data_o.in_set) |-> (out_data_o.red == '0 && out_data_o.green == '0 && out_data_o.blue == '0), "in-set pixel not black")

endmodule

`default_nettype wire

/* verif/tb_mandelbrot_escape_time_pixel_core.sv */
// Self-checking testbench for the escape-time pixel core: directed and random pixels.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_pixel_core;
  import mbrot_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 32;
  localparam int RANDOM_ITEMS   = 272;

  // Expected-result calculator for the core: maps a pixel to c, runs the
  // escape-time loop in Q4.28 and looks the count up in its own palette.
  class escape_color_predictor;
    localparam longint unsigned UNIT         = 64'd268435456;
    localparam longint unsigned TURN         = 64'd1686629713;
    localparam longint unsigned HALF_TURN    = 64'd843314857;
    localparam longint unsigned QUARTER_TURN = 64'd421657428;
    localparam longint unsigned THIRD        = 64'd562209904;
    localparam longint unsigned TWO_THIRDS   = 64'd1124419809;
    localparam longint          ESCAPE_Q28   = 64'sd1073741824;

    typedef struct packed {
      pix_in_t  px;
      pix_out_t want;
    } pending_t;

    longint      x_edge;
    longint      y_edge;
    longint      step;
    int unsigned limit;
    logic [23:0] shade [2048];
    pending_t    expected_pixels [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned in_set_results;

    function new();
      x_edge = -64'sd402653184;
      y_edge = 64'sd107374182;
      step   = 64'sd104858;
      limit  = 2024;
      mismatches = 0;
      checked = 0;
      in_set_results = 0;
      for (int n = 0; n < 2048; n++) begin
        shade[n] = color_for(n);
      end
    endfunction

    // Q16 fifth root: largest r whose fourfold truncated product stays <= n.
    function longint unsigned fifth_root(longint unsigned n);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned p;
      longint unsigned target;
      lo = 0;
      hi = (64'd1 << 20) - 1;
      target = n << 16;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        p = mid;
        repeat (4) p = (p * mid) >> 16;
        if (p <= target) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      return lo;
    endfunction

    // Q28 sine on [0, 2pi): fold to the first quadrant, Horner series to x^11.
    function longint sine(longint unsigned ang);
      longint unsigned a;
      longint unsigned x2;
      longint unsigned acc;
      longint          s;
      logic            neg;
      a = ang;
      neg = (a >= HALF_TURN);
      if (neg) begin
        a = a - HALF_TURN;
      end
      if (a > QUARTER_TURN) begin
        a = HALF_TURN - a;
      end
      x2 = (a * a) >> 28;
      acc = UNIT;
      // divisors 10*11, 8*9, 6*7, 4*5, 2*3
      for (int j = 0; j < 5; j++) begin
        acc = UNIT - ((x2 * acc) >> 28) / ((10 - 2 * j) * (11 - 2 * j));
      end
      s = (a * acc) >> 28;
      return neg ? -s : s;
    endfunction

    function logic [7:0] channel_byte(longint unsigned ang);
      longint          s;
      longint unsigned lvl;
      s = sine(ang % TURN);
      lvl = 10 * s + 17 * UNIT;
      lvl = (lvl * 255) / (27 * UNIT);
      return (lvl > 255) ? 8'd255 : lvl[7:0];
    endfunction

    function logic [23:0] color_for(int unsigned n);
      longint unsigned ang;
      ang = (64'd11 * fifth_root(n)) << 12;
      return {channel_byte(ang), channel_byte(ang + THIRD), channel_byte(ang + TWO_THIRDS)};
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_X_BASE:     x_edge = $signed(data);
        CFG_Y_BASE:     y_edge = $signed(data);
        CFG_PIXEL_STEP: step = 64'(data[27:0]);
        CFG_ITER_LIMIT: limit = 32'(data[10:0]);
        default: ;
      endcase
    endfunction

    function void note_pixel(pix_in_t px);
      longint      c_re;
      longint      c_im;
      longint      z_re;
      longint      z_im;
      longint      re_sq;
      longint      im_sq;
      longint      re_im2;
      int unsigned n;
      pending_t    item;
      c_re = clamp32(x_edge + longint'(px.col) * step);
      c_im = clamp32(y_edge - longint'(px.row) * step);
      z_re = c_re;
      z_im = c_im;
      n = 0;
      while (n < limit) begin
        re_sq = (z_re * z_re) >>> 28;
        im_sq = (z_im * z_im) >>> 28;
        if (re_sq + im_sq > ESCAPE_Q28) begin
          break;
        end
        n++;
        re_im2 = (z_re * z_im) >>> 27;
        z_im = clamp32(c_im + re_im2);
        z_re = clamp32(c_re + re_sq - im_sq);
      end
      item.px = px;
      item.want.iterations = n[10:0];
      item.want.in_set = (n >= limit);
      if (item.want.in_set) begin
        {item.want.red, item.want.green, item.want.blue} = '0;
      end else begin
        {item.want.red, item.want.green, item.want.blue} = shade[(n > 2047) ? 2047 : n];
      end
      expected_pixels.push_back(item);
    endfunction

    function void check_pixel(pix_out_t got);
      pending_t item;
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with nothing outstanding: rgb %0d/%0d/%0d iterations %0d in_set %0b",
                 $time, got.red, got.green, got.blue, got.iterations, got.in_set);
        mismatches++;
        return;
      end
      item = expected_pixels.pop_front();
      checked++;
      if (item.want.in_set) begin
        in_set_results++;
      end
      if (got.red !== item.want.red || got.green !== item.want.green ||
          got.blue !== item.want.blue || got.iterations !== item.want.iterations ||
          got.in_set !== item.want.in_set) begin
        $display("%0t: pixel (%0d,%0d) expected rgb %0d/%0d/%0d it %0d in_set %0b, got %0d/%0d/%0d it %0d in_set %0b",
                 $time, item.px.row, item.px.col,
                 item.want.red, item.want.green, item.want.blue, item.want.iterations,
                 item.want.in_set, got.red, got.green, got.blue, got.iterations, got.in_set);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  pix_in_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  pix_out_t             out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_X_BASE;
  logic [WORD_W-1:0]    cfg_data_i = '0;

  escape_color_predictor escape_pred;
  logic                  idle_on = 1'b1;   // random gaps on both sides when set
  int                    quiet_cycles = 0;
  int                    pixels_sent = 0;
  int                    cfg_writes = 0;
  int                    windows = 0;

  mandelbrot_escape_time_pixel_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function int pick_gap();
    return idle_on ? $urandom_range(0, 16) : 0;
  endfunction

  // Transaction monitor: all handshakes are sampled at the rising edge, so
  // the values seen are the ones from before the edge. Also the watchdog.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (in_valid_i && !in_stall_o) begin
      escape_pred.note_pixel(in_data_i);
    end
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      escape_pred.check_pixel(out_data_o);
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: stall for a random number of cycles, then take one result.
  // The stall is raised independently of valid so it lands on every phase.
  initial begin : result_sink
    int hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // One pixel transaction. Valid stays high when the next pixel follows
  // back to back; it is only lowered when a gap is drawn.
  task automatic send_pixel(input int row, input int col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{row: row[COORD_W-1:0], col: col[COORD_W-1:0]};
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
  endtask

  // Stop sending and hold off until every outstanding pixel has come back.
  // It first lets the monitor log the last accepted pixel.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (escape_pred.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    escape_pred.write_register(idx, value);
    cfg_writes++;
  endtask

  // Rewrite all four registers; only called with the core idle. Unused
  // upper bits of step and count carry junk, which the core must drop.
  task automatic program_window(input logic [31:0] x, input logic [31:0] y,
                                input logic [27:0] step, input logic [10:0] count);
    write_reg(CFG_X_BASE, x);
    write_reg(CFG_Y_BASE, y);
    write_reg(CFG_PIXEL_STEP, {4'($urandom), step});
    write_reg(CFG_ITER_LIMIT, {21'($urandom), count});
    cfg_valid_i <= 1'b0;
    windows++;
  endtask

  initial begin
    logic [31:0] x;
    logic [31:0] y;
    logic [27:0] st;
    logic [10:0] count;
    int          batch;
    int          random_sent;

    escape_pred = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window (-1.5 + 0.4i, fine step, limit 2024): grid corners and middle.
    send_pixel(0, 0);
    send_pixel(2047, 2047);
    send_pixel(0, 2047);
    send_pixel(2047, 0);
    send_pixel(1024, 512);
    wait_for_results();

    // Window -2..1 by 1.5i..-1.5i at the full limit. Pixel (1024,1365) sits
    // next to the origin and runs all 2047 iterations; (1024,0) is c = -2,
    // where |z|^2 stays exactly 4 and must not count as an escape.
    program_window(32'hE000_0000, 32'd402653184, 28'd393216, 11'd2047);
    send_pixel(1024, 1365);
    send_pixel(1024, 0);
    send_pixel(0, 0);
    send_pixel(1024, 2047);
    wait_for_results();

    // Zero limit: no iteration, reported as in the set and black.
    program_window(32'hE000_0000, 32'd402653184, 28'd393216, 11'd0);
    send_pixel(1024, 1365);
    send_pixel(0, 0);
    wait_for_results();

    // Limit of one.
    program_window(32'hE000_0000, 32'd402653184, 28'd393216, 11'd1);
    send_pixel(1024, 1365);
    send_pixel(0, 0);
    wait_for_results();

    // Register extremes; the grid sums saturate at both ends of the word.
    program_window(32'h7FFF_FFFF, 32'h8000_0000, 28'hFFF_FFFF, 11'd20);
    send_pixel(2047, 2047);
    send_pixel(0, 0);
    wait_for_results();
    program_window(32'h8000_0000, 32'h7FFF_FFFF, 28'd1, 11'd2047);
    send_pixel(0, 2047);
    send_pixel(2047, 0);
    wait_for_results();

    // Zero step: every pixel lands on the origin.
    program_window(32'd0, 32'd0, 28'd0, 11'd64);
    send_pixel(1500, 700);
    wait_for_results();

    // Random windows. Mostly a view around the set with a random zoom so the
    // counts spread; now and then fully random words. Long limits get short
    // batches to keep the run length bounded.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        x  = $urandom_range(0, 671088640) - 603979776;
        y  = $urandom_range(0, 335544320);
        st = 28'($urandom_range(1, 393216 >> $urandom_range(0, 10)));
      end else begin
        x  = $urandom;
        y  = $urandom;
        st = 28'($urandom);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: count = 11'($urandom_range(1, 16));
        4, 5, 6:    count = 11'($urandom_range(17, 96));
        7, 8:       count = 11'($urandom_range(97, 400));
        default:    count = 11'($urandom_range(401, 2047));
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      program_window(x, y, st, count);
      batch = (count > 400) ? 8 : 32;
      if (batch > RANDOM_ITEMS - random_sent) begin
        batch = RANDOM_ITEMS - random_sent;
      end
      repeat (batch) begin
        send_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
        random_sent++;
        // occasional full drain in the middle of a batch
        if ($urandom_range(0, 31) == 0) begin
          wait_for_results();
        end
      end
      wait_for_results();
    end

    // Anything arriving now is unexpected and caught by the monitor.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run: %0d pixels sent, %0d results checked (%0d in the set), %0d windows, %0d register writes",
             pixels_sent, escape_pred.checked, escape_pred.in_set_results, windows, cfg_writes);
    if (escape_pred.mismatches == 0 && escape_pred.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
